/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that the antecedent implies the consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |-> (cons), msg)

// Checks that the antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

/* rtl/lat_pkg.sv */
// ---------------------------------------------------------------------------
// Lever-arm transform package
// Payload types, register indexes, widths and helpers of the transform.
// ---------------------------------------------------------------------------
`default_nettype none

package lat_pkg;

	localparam int W          = 24;
	localparam int QW         = 18;
	localparam int DTW        = 20;
	localparam int RW         = 23;
	localparam int TW         = 33;
	localparam int CW         = 42;
	localparam int GW         = 41;
	localparam int SW         = 43;
	localparam int DWW        = 32;
	localparam int MAGW       = 44;
	localparam int DIV_STEPS  = 4;
	localparam int DIV_STAGES = MAGW / DIV_STEPS;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int OW         = 53;

	localparam logic signed [20:0] US_PER_S = 21'sd1000000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROT_QW = 3'd0,
		REG_ROT_QX = 3'd1,
		REG_ROT_QY = 3'd2,
		REG_ROT_QZ = 3'd3,
		REG_ARM_X  = 3'd4,
		REG_ARM_Y  = 3'd5,
		REG_ARM_Z  = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic signed [W-1:0]   rate_now_x;
		logic signed [W-1:0]   rate_now_y;
		logic signed [W-1:0]   rate_now_z;
		logic signed [W-1:0]   rate_prev_x;
		logic signed [W-1:0]   rate_prev_y;
		logic signed [W-1:0]   rate_prev_z;
		logic signed [W-1:0]   accel_x;
		logic signed [W-1:0]   accel_y;
		logic signed [W-1:0]   accel_z;
		logic        [DTW-1:0] interval_us;
	} in_item_t;

	typedef struct packed {
		logic signed [W-1:0] body_rate_x;
		logic signed [W-1:0] body_rate_y;
		logic signed [W-1:0] body_rate_z;
		logic signed [W-1:0] body_accel_x;
		logic signed [W-1:0] body_accel_y;
		logic signed [W-1:0] body_accel_z;
	} out_item_t;

	typedef logic [2:0][2:0][RW-1:0] rmat_t;

	typedef struct packed {
		logic [2:0][W-1:0]  wn;
		logic [2:0][W-1:0]  acc;
		logic [2:0][CW-1:0] c;
		logic               dtz;
	} side_t;

	typedef struct packed {
		logic [DTW-1:0]  rem;
		logic [MAGW-1:0] nq;
	} div_lane_t;

	typedef struct packed {
		div_lane_t [2:0] lane;
		logic [2:0]      neg;
		logic [DTW-1:0]  dvs;
		side_t           side;
	} div_t;

	function automatic logic signed [W-1:0] sat24(input logic signed [OW-1:0] x);
		logic signed [OW-1:0] hi;
		logic signed [OW-1:0] lo;
		hi = OW'(8388607);
		lo = -OW'(8388608);
		if (x > hi) begin
			return 24'sh7FFFFF;
		end else if (x < lo) begin
			return 24'sh800000;
		end
		return x[W-1:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/imu_lever_arm_transform.sv */
// ---------------------------------------------------------------------------
// IMU lever-arm frame transform
// Accepts one transfer per cycle while the output is not stalled.
// The angular-acceleration divider has 11 stages of 4 bits.
// A stalled result freezes the whole pipeline in place.
// Reset clears all valid bits and loads the identity quaternion and zero arm.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module imu_lever_arm_transform (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wen,
	input  wire logic [lat_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lat_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire lat_pkg::in_item_t              in_item,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output lat_pkg::out_item_t                  out_item
);
	import lat_pkg::*;

	logic              en;
	rmat_t             rmat;
	logic [2:0][W-1:0] arm_p;
	logic signed [W-1:0] arm [3];
	logic signed [W-1:0] wn_in [3];
	logic signed [W-1:0] wp_in [3];
	logic signed [W-1:0] acc_in [3];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	logic signed [W:0]     d_s1 [3];
	logic signed [47:0]    ta_s1 [3];
	logic signed [47:0]    tb_s1 [3];
	logic signed [W-1:0]   wn_s1 [3];
	logic signed [W-1:0]   acc_s1 [3];
	logic [DTW-1:0]        dt_s1;

	logic signed [TW-1:0]  t_s2 [3];
	logic signed [44:0]    m_s2 [3];
	logic signed [W-1:0]   wn_s2 [3];
	logic signed [W-1:0]   acc_s2 [3];
	logic [DTW-1:0]        dt_s2;

	logic signed [56:0]    ca_s3 [3];
	logic signed [56:0]    cb_s3 [3];
	logic [MAGW-1:0]       mag_s3 [3];
	logic [2:0]            neg_s3;
	logic signed [W-1:0]   wn_s3 [3];
	logic signed [W-1:0]   acc_s3 [3];
	logic [DTW-1:0]        dt_s3;

	div_t                  div_s4;
	div_t                  div_c;
	div_t                  dq;
	logic                  dv;

	logic signed [DWW-1:0] dw_s5 [3];
	side_t                 side_s5;
	logic signed [55:0]    ga_s6 [3];
	logic signed [55:0]    gb_s6 [3];
	side_t                 side_s6;
	logic signed [GW-1:0]  g_s7 [3];
	side_t                 side_s7;
	logic signed [SW-1:0]  s_s8 [3];
	logic signed [W-1:0]   wn_s8 [3];
	logic signed [65:0]    ra_s9 [3][3];
	logic signed [46:0]    rr_s9 [3][3];

	logic signed [GW-1:0]  g_c [3];
	logic signed [CW-1:0]  c_c [3];
	logic signed [TW-1:0]  t_c [3];
	logic signed [OW-1:0]  ro_c [3];
	logic signed [OW-1:0]  rr_c [3];

	lat_rmat u_rmat (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rmat      (rmat),
		.arm       (arm_p)
	);

	assign en       = !(out_valid && out_stall);
	assign in_stall = out_valid && out_stall;

	assign wn_in[0]  = in_item.rate_now_x;
	assign wn_in[1]  = in_item.rate_now_y;
	assign wn_in[2]  = in_item.rate_now_z;
	assign wp_in[0]  = in_item.rate_prev_x;
	assign wp_in[1]  = in_item.rate_prev_y;
	assign wp_in[2]  = in_item.rate_prev_z;
	assign acc_in[0] = in_item.accel_x;
	assign acc_in[1] = in_item.accel_y;
	assign acc_in[2] = in_item.accel_z;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		localparam int I1 = (i + 1) % 3;
		localparam int I2 = (i + 2) % 3;
		logic signed [48:0] tdif;
		logic signed [57:0] cdif;
		logic signed [56:0] gdif;
		logic signed [67:0] rsum;
		logic signed [48:0] wsum;
		logic [MAGW:0]      q_ext;

		assign arm[i] = arm_p[i];
		assign tdif   = 49'(ta_s1[i]) - 49'(tb_s1[i]);
		assign t_c[i] = TW'((tdif + 49'sd32768) >>> 16);
		assign cdif   = 58'(ca_s3[i]) - 58'(cb_s3[i]);
		assign c_c[i] = CW'((cdif + 58'sd32768) >>> 16);
		assign gdif   = 57'(ga_s6[i]) - 57'(gb_s6[i]);
		assign g_c[i] = side_s6.dtz ? '0 : GW'((gdif + 57'sd32768) >>> 16);
		assign rsum   = 68'(ra_s9[0][i]) + 68'(ra_s9[1][i]) + 68'(ra_s9[2][i]);
		assign ro_c[i] = OW'((rsum + 68'sd32768) >>> 16);
		assign wsum   = 49'(rr_s9[0][i]) + 49'(rr_s9[1][i]) + 49'(rr_s9[2][i]);
		assign rr_c[i] = OW'((wsum + 49'sd32768) >>> 16);
		assign q_ext  = {1'b0, dq.lane[i].nq};

		always_ff @(posedge clk) begin
			if (en) begin
				ta_s1[i] <= wn_in[I1] * arm[I2];
				tb_s1[i] <= wn_in[I2] * arm[I1];
				ca_s3[i] <= wn_s2[I1] * t_s2[I2];
				cb_s3[i] <= wn_s2[I2] * t_s2[I1];
				ga_s6[i] <= dw_s5[I1] * arm[I2];
				gb_s6[i] <= dw_s5[I2] * arm[I1];
				if (dq.neg[i]) begin
					if (q_ext > (MAGW+1)'(64'd2147483648)) begin
						dw_s5[i] <= 32'sh80000000;
					end else begin
						dw_s5[i] <= -$signed(dq.lane[i].nq[DWW-1:0]);
					end
				end else begin
					if (q_ext > (MAGW+1)'(64'd2147483647)) begin
						dw_s5[i] <= 32'sh7FFFFFFF;
					end else begin
						dw_s5[i] <= $signed(dq.lane[i].nq[DWW-1:0]);
					end
				end
			end
		end
	end

	always_comb begin
		div_c.dvs       = dt_s3;
		div_c.neg       = neg_s3;
		div_c.side.dtz  = (dt_s3 == '0);
		for (int i = 0; i < 3; i++) begin
			div_c.lane[i].rem = '0;
			div_c.lane[i].nq  = mag_s3[i];
			div_c.side.wn[i]  = wn_s3[i];
			div_c.side.acc[i] = acc_s3[i];
			div_c.side.c[i]   = c_c[i];
		end
	end

	always_ff @(posedge clk) begin
		logic signed [45:0] mfull;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i]   <= 25'(wn_in[i]) - 25'(wp_in[i]);
				wn_s1[i]  <= wn_in[i];
				acc_s1[i] <= acc_in[i];
				t_s2[i]   <= t_c[i];
				mfull      = d_s1[i] * US_PER_S;
				m_s2[i]   <= mfull[44:0];
				wn_s2[i]  <= wn_s1[i];
				acc_s2[i] <= acc_s1[i];
				neg_s3[i] <= m_s2[i][44];
				mag_s3[i] <= m_s2[i][44] ? MAGW'(-m_s2[i]) : MAGW'(m_s2[i]);
				wn_s3[i]  <= wn_s2[i];
				acc_s3[i] <= acc_s2[i];
				g_s7[i]   <= g_c[i];
				s_s8[i]   <= SW'($signed(side_s7.acc[i])) + SW'($signed(side_s7.c[i]))
					+ SW'(g_s7[i]);
				wn_s8[i]  <= $signed(side_s7.wn[i]);
				for (int j = 0; j < 3; j++) begin
					ra_s9[j][i] <= $signed(rmat[j][i]) * s_s8[j];
					rr_s9[j][i] <= $signed(rmat[j][i]) * wn_s8[j];
				end
			end
			dt_s1   <= in_item.interval_us;
			dt_s2   <= dt_s1;
			dt_s3   <= dt_s2;
			div_s4  <= div_c;
			side_s5 <= dq.side;
			side_s6 <= side_s5;
			side_s7 <= side_s6;
			out_item.body_rate_x  <= sat24(rr_c[0]);
			out_item.body_rate_y  <= sat24(rr_c[1]);
			out_item.body_rate_z  <= sat24(rr_c[2]);
			out_item.body_accel_x <= sat24(ro_c[0]);
			out_item.body_accel_y <= sat24(ro_c[1]);
			out_item.body_accel_z <= sat24(ro_c[2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			v_s7      <= 1'b0;
			v_s8      <= 1'b0;
			v_s9      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= dv;
			v_s6      <= v_s5;
			v_s7      <= v_s6;
			v_s8      <= v_s7;
			v_s9      <= v_s8;
			out_valid <= v_s9;
		end
	end

	lat_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (v_s4),
		.in_d    (div_s4),
		.out_vld (dv),
		.out_d   (dq)
	);

	`ASSERT_NEXT(a_zero_interval, en && v_s6 && side_s6.dtz,
		g_s7[0] == '0 && g_s7[1] == '0 && g_s7[2] == '0,
		"Zero interval produced an angular-acceleration term.")
	`ASSERT_IMPL(a_div_remainder, dv && dq.dvs != '0,
		dq.lane[0].rem < dq.dvs && dq.lane[1].rem < dq.dvs && dq.lane[2].rem < dq.dvs,
		"Divider remainder not below the divisor.")
	`ASSERT_NEXT(a_last_stage, en && v_s9, out_valid,
		"Last stage item did not reach the output register.")

endmodule

`default_nettype wire

/* rtl/lat_rmat.sv */
// ---------------------------------------------------------------------------
// Mounting configuration and rotation matrix
// Holds the quaternion and lever arm registers and builds the Q.16 matrix.
// ---------------------------------------------------------------------------
`default_nettype none

module lat_rmat (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wen,
	input  wire logic [lat_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lat_pkg::CFG_DATA_W-1:0] cfg_data,
	output lat_pkg::rmat_t                      rmat,
	output logic [2:0][lat_pkg::W-1:0]          arm
);
	import lat_pkg::*;

	localparam logic signed [39:0] ONE = 40'sd4294967296;

	logic signed [QW-1:0] qw_q, qx_q, qy_q, qz_q;
	logic signed [W-1:0]  ax_q, ay_q, az_q;
	logic signed [35:0]   prod_q [9];
	rmat_t                rmat_q;
	logic signed [39:0]   e [3][3];
	logic signed [39:0]   pe [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qw_q <= 18'sd65536;
			qx_q <= '0;
			qy_q <= '0;
			qz_q <= '0;
			ax_q <= '0;
			ay_q <= '0;
			az_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_ROT_QW: qw_q <= cfg_data[QW-1:0];
				REG_ROT_QX: qx_q <= cfg_data[QW-1:0];
				REG_ROT_QY: qy_q <= cfg_data[QW-1:0];
				REG_ROT_QZ: qz_q <= cfg_data[QW-1:0];
				REG_ARM_X:  ax_q <= cfg_data[W-1:0];
				REG_ARM_Y:  ay_q <= cfg_data[W-1:0];
				REG_ARM_Z:  az_q <= cfg_data[W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q[0] <= qx_q * qx_q;
		prod_q[1] <= qy_q * qy_q;
		prod_q[2] <= qz_q * qz_q;
		prod_q[3] <= qx_q * qy_q;
		prod_q[4] <= qx_q * qz_q;
		prod_q[5] <= qy_q * qz_q;
		prod_q[6] <= qw_q * qx_q;
		prod_q[7] <= qw_q * qy_q;
		prod_q[8] <= qw_q * qz_q;
	end

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			pe[k] = 40'(prod_q[k]);
		end
		e[0][0] = ONE - ((pe[1] + pe[2]) <<< 1);
		e[0][1] = (pe[3] - pe[8]) <<< 1;
		e[0][2] = (pe[4] + pe[7]) <<< 1;
		e[1][0] = (pe[3] + pe[8]) <<< 1;
		e[1][1] = ONE - ((pe[0] + pe[2]) <<< 1);
		e[1][2] = (pe[5] - pe[6]) <<< 1;
		e[2][0] = (pe[4] - pe[7]) <<< 1;
		e[2][1] = (pe[5] + pe[6]) <<< 1;
		e[2][2] = ONE - ((pe[0] + pe[1]) <<< 1);
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			for (int i = 0; i < 3; i++) begin
				rmat_q[j][i] <= 23'((e[j][i] + 40'sd32768) >>> 16);
			end
		end
	end

	assign rmat   = rmat_q;
	assign arm[0] = ax_q;
	assign arm[1] = ay_q;
	assign arm[2] = az_q;

endmodule

`default_nettype wire

/* rtl/lat_div.sv */
// ---------------------------------------------------------------------------
// Pipelined magnitude divider
// Three restoring division lanes that retire DIV_STEPS quotient bits per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module lat_div (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_vld,
	input  wire lat_pkg::div_t in_d,
	output logic               out_vld,
	output lat_pkg::div_t      out_d
);
	import lat_pkg::*;

	div_t                  div_s [DIV_STAGES];
	logic [DIV_STAGES-1:0] vld_s;

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		div_t src;
		div_t nxt;
		logic src_vld;

		if (k == 0) begin : g_first
			assign src     = in_d;
			assign src_vld = in_vld;
		end else begin : g_next
			assign src     = div_s[k-1];
			assign src_vld = vld_s[k-1];
		end

		always_comb begin
			logic [DTW:0] tmp;
			logic         qb;
			nxt = src;
			for (int l = 0; l < 3; l++) begin
				for (int s = 0; s < DIV_STEPS; s++) begin
					tmp = {nxt.lane[l].rem, nxt.lane[l].nq[MAGW-1]};
					qb  = (tmp >= {1'b0, nxt.dvs});
					if (qb) begin
						tmp = tmp - {1'b0, nxt.dvs};
					end
					nxt.lane[l].rem = tmp[DTW-1:0];
					nxt.lane[l].nq  = {nxt.lane[l].nq[MAGW-2:0], qb};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k] <= nxt;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= src_vld;
			end
		end
	end

	assign out_d   = div_s[DIV_STAGES-1];
	assign out_vld = vld_s[DIV_STAGES-1];

endmodule

`default_nettype wire
